FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/lob_pkg.sv
package lob_pkg;

    localparam int unsigned LOB_BOOK_DEPTH = 1024;
    localparam int unsigned FIELD_W        = 30;
    localparam int unsigned ENTRY_W        = 2 * FIELD_W;
    localparam logic [FIELD_W-1:0] BACKLOG_MOD = 30'd1000000007;

    typedef struct packed {
        logic [FIELD_W-1:0] order_price;
        logic [FIELD_W-1:0] order_amount;
        logic               order_side;
    } t_order_in;

    typedef struct packed {
        logic [FIELD_W-1:0] executed_units;
        logic [FIELD_W-1:0] backlog_total_mod;
        logic               book_full;
    } t_order_out;

    // Reduce a 30-bit value below the modulus; one subtract suffices.
    function automatic logic [FIELD_W-1:0] mod_reduce(input logic [FIELD_W-1:0] x);
        return (x >= BACKLOG_MOD) ? (x - BACKLOG_MOD) : x;
    endfunction

    function automatic logic [FIELD_W-1:0] mod_sub(input logic [FIELD_W-1:0] t,
                                                   input logic [FIELD_W-1:0] e);
        logic [FIELD_W:0] s;
        s = {1'b0, t} + {1'b0, BACKLOG_MOD} - {1'b0, mod_reduce(e)};
        return (s >= {1'b0, BACKLOG_MOD}) ? FIELD_W'(s - {1'b0, BACKLOG_MOD})
                                          : FIELD_W'(s);
    endfunction

    function automatic logic [FIELD_W-1:0] mod_add(input logic [FIELD_W-1:0] t,
                                                   input logic [FIELD_W-1:0] r);
        logic [FIELD_W:0] s;
        s = {1'b0, t} + {1'b0, mod_reduce(r)};
        return (s >= {1'b0, BACKLOG_MOD}) ? FIELD_W'(s - {1'b0, BACKLOG_MOD})
                                          : FIELD_W'(s);
    endfunction

endpackage

FILE: sv/lob_book_mem.sv
module lob_book_mem
    import lob_pkg::*;
#(
    parameter int unsigned ADDR_W = 11
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic [ENTRY_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

FILE: sv/limit_order_book_matcher.sv
// Limit order book matcher. Orders arrive one per input transfer; each
// produces exactly one result transfer carrying the units executed against
// the opposite book, the total of resting units in both books modulo
// 1000000007, and a flag set when a remainder was dropped because its own
// book already held BOOK_DEPTH entries. Both books live in one synchronous
// memory (bank bit selects buy or sell) kept in arrival order, so
// price-time priority falls out of a linear scan that keeps the first
// strictly better price. An order passes through CHECK, then for each
// match step a SCAN of the opposite book and a DECIDE, with SHIFT
// moving the entries after a fully consumed one down one per cycle
// through the single memory port pair, and ends with REST, ADD and DONE.
// An order with nothing left to fill or an empty opposite book goes from
// CHECK straight to REST. A result that still waits in the output
// register holds the next result back for as long as the receiver stalls.
// The block takes one order at a time; o_in_stall is high while an order is
// in work, and a finished result waits in the output register without
// blocking the next order from entering.
module limit_order_book_matcher
    import lob_pkg::*;
#(
    parameter int unsigned BOOK_DEPTH = LOB_BOOK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_order_in  i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_order_out o_out_data
);

`include "assert_macros.svh"

    localparam int unsigned AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

    typedef enum logic [2:0] {
        IDLE, CHECK, SCAN, DECIDE, SHIFT, REST, ADD, DONE
    } t_state;

    t_state             r_state, n_state;
    logic [FIELD_W-1:0] r_price, n_price;
    logic [FIELD_W-1:0] r_amt, n_amt;
    logic               r_side, n_side;
    logic [FIELD_W-1:0] r_exec, n_exec;
    logic [FIELD_W-1:0] r_total, n_total;
    logic [CW-1:0]      r_buy_cnt, n_buy_cnt;
    logic [CW-1:0]      r_sell_cnt, n_sell_cnt;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_best_idx, n_best_idx;
    logic [ENTRY_W-1:0] r_best, n_best;
    logic               r_full, n_full;
    logic               r_rested, n_rested;
    logic               r_out_valid, n_out_valid;
    t_order_out         r_out_data, n_out_data;

    logic               mem_we;
    logic [AW:0]        mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

    logic [CW-1:0]      opp_cnt, own_cnt;
    logic [FIELD_W-1:0] rd_price, best_price, best_amt, take;
    logic               better, crosses;

    lob_book_mem #(.ADDR_W(AW + 1)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    // Sell orders (side 1) hit the buy book, buy orders hit the sell book.
    assign opp_cnt    = r_side ? r_buy_cnt : r_sell_cnt;
    assign own_cnt    = r_side ? r_sell_cnt : r_buy_cnt;
    assign rd_price   = mem_rdata[ENTRY_W-1:FIELD_W];
    assign best_price = r_best[ENTRY_W-1:FIELD_W];
    assign best_amt   = r_best[FIELD_W-1:0];
    // Strict compare keeps the oldest entry on equal prices.
    assign better     = r_side ? (rd_price > best_price) : (rd_price < best_price);
    assign crosses    = r_side ? (best_price >= r_price) : (best_price <= r_price);
    assign take       = (r_amt < best_amt) ? r_amt : best_amt;

    assign o_in_stall  = (r_state != IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_price     = r_price;
        n_amt       = r_amt;
        n_side      = r_side;
        n_exec      = r_exec;
        n_total     = r_total;
        n_buy_cnt   = r_buy_cnt;
        n_sell_cnt  = r_sell_cnt;
        n_idx       = r_idx;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_full      = r_full;
        n_rested    = r_rested;
        n_out_data  = r_out_data;
        // Drop the held result once it has been transferred.
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;

        unique case (r_state)
            IDLE: begin
                if (i_in_valid) begin
                    n_price = i_in_data.order_price;
                    n_amt   = i_in_data.order_amount;
                    n_side  = i_in_data.order_side;
                    n_exec  = '0;
                    n_state = CHECK;
                end
            end
            CHECK: begin
                if (r_amt == '0 || opp_cnt == '0) begin
                    n_state = REST;
                end else begin
                    // Start a best-price scan of the opposite book at entry 0.
                    mem_raddr = {~r_side, {AW{1'b0}}};
                    n_idx     = '0;
                    n_state   = SCAN;
                end
            end
            SCAN: begin
                // mem_rdata holds entry r_idx of the opposite book.
                if (r_idx == '0 || better) begin
                    n_best_idx = r_idx;
                    n_best     = mem_rdata;
                end
                if (CW'(r_idx) == opp_cnt - CW'(1)) begin
                    n_state = DECIDE;
                end else begin
                    n_idx     = r_idx + AW'(1);
                    mem_raddr = {~r_side, r_idx + AW'(1)};
                end
            end
            DECIDE: begin
                if (!crosses) begin
                    n_state = REST;
                end else begin
                    n_amt  = r_amt - take;
                    n_exec = r_exec + take;
                    if (best_amt > take) begin
                        // Partial fill: entry keeps its place.
                        mem_we    = 1'b1;
                        mem_waddr = {~r_side, r_best_idx};
                        mem_wdata = {best_price, best_amt - take};
                        n_state   = CHECK;
                    end else if (CW'(r_best_idx) == opp_cnt - CW'(1)) begin
                        if (r_side) n_buy_cnt = r_buy_cnt - CW'(1);
                        else        n_sell_cnt = r_sell_cnt - CW'(1);
                        n_state = CHECK;
                    end else begin
                        // Close the gap: shift the tail down one entry.
                        n_idx     = r_best_idx;
                        mem_raddr = {~r_side, r_best_idx + AW'(1)};
                        n_state   = SHIFT;
                    end
                end
            end
            SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = {~r_side, r_idx};
                mem_wdata = mem_rdata;
                if (CW'(r_idx) + CW'(2) == opp_cnt) begin
                    if (r_side) n_buy_cnt = r_buy_cnt - CW'(1);
                    else        n_sell_cnt = r_sell_cnt - CW'(1);
                    n_state = CHECK;
                end else begin
                    n_idx     = r_idx + AW'(1);
                    mem_raddr = {~r_side, r_idx + AW'(2)};
                end
            end
            REST: begin
                n_total  = mod_sub(r_total, r_exec);
                n_full   = 1'b0;
                n_rested = 1'b0;
                if (r_amt != '0) begin
                    if (own_cnt < DEPTH_C) begin
                        mem_we    = 1'b1;
                        mem_waddr = {r_side, own_cnt[AW-1:0]};
                        mem_wdata = {r_price, r_amt};
                        if (r_side) n_sell_cnt = r_sell_cnt + CW'(1);
                        else        n_buy_cnt = r_buy_cnt + CW'(1);
                        n_rested = 1'b1;
                    end else begin
                        n_full = 1'b1;
                    end
                end
                n_state = ADD;
            end
            ADD: begin
                if (r_rested) begin
                    n_total = mod_add(r_total, r_amt);
                end
                n_state = DONE;
            end
            DONE: begin
                // Hold here until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                  = 1'b1;
                    n_out_data.executed_units    = r_exec;
                    n_out_data.backlog_total_mod = r_total;
                    n_out_data.book_full         = r_full;
                    n_state                      = IDLE;
                end
            end
            default: n_state = IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= IDLE;
            r_total     <= '0;
            r_buy_cnt   <= '0;
            r_sell_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_buy_cnt   <= n_buy_cnt;
            r_sell_cnt  <= n_sell_cnt;
            r_out_valid <= n_out_valid;
        end
        r_price    <= n_price;
        r_amt      <= n_amt;
        r_side     <= n_side;
        r_exec     <= n_exec;
        r_idx      <= n_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_full     <= n_full;
        r_rested   <= n_rested;
        r_out_data <= n_out_data;
    end

    `ASSERT_IMPLY(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_buy_cnt <= DEPTH_C) && (r_sell_cnt <= DEPTH_C))
    `ASSERT_IMPLY(a_total_range, i_clk, i_rst_n, 1'b1, r_total < BACKLOG_MOD)
    `ASSERT_NEXT(a_accept_check, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == CHECK)
    `ASSERT_IMPLY(a_full_no_rest, i_clk, i_rst_n, r_state == ADD, !(r_full && r_rested))

endmodule
